@@ rtl/fhli_pkg.sv @@
// ----------------------------------------------------------------------------
// Foil hit lockout indicator package
// Shared types, register codes, reset values and time helpers.
// ----------------------------------------------------------------------------
package fhli_pkg;

    // Width of the tick counter and of all time stamps.
    localparam int TIME_BITS = 16;
    // Width used when comparing a wrapped time difference with a register.
    localparam int CMP_W     = (TIME_BITS > 16) ? TIME_BITS : 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [TIME_BITS-1:0] t_time;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HIT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUZZER     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DISC_WIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DISC_COUNT = 3'd5;

    // Register values after reset.
    localparam logic [9:0]  RST_MIN_HIT    = 10'd14;
    localparam logic [13:0] RST_LOCKOUT    = 14'd300;
    localparam logic [15:0] RST_BUZZER     = 16'd1500;
    localparam logic [15:0] RST_LIGHT      = 16'd1500;
    localparam logic [13:0] RST_DISC_WIN   = 14'd500;
    localparam logic [7:0]  RST_DISC_COUNT = 8'd3;

    localparam logic [7:0]  REPEAT_MAX = 8'd255;

    typedef struct packed {
        logic [9:0]  min_press_ticks;
        logic [13:0] lockout_ticks;
        logic [15:0] buzz_ticks;
        logic [15:0] light_time;
        logic [13:0] disconnect_window;
        logic [7:0]  disconnect_count;
    } t_cfg;

    typedef struct packed {
        logic red_lamp;
        logic green_lamp;
        logic buzzer_on;
        logic buzzer_enabled;
    } t_result;

    typedef enum logic [2:0] {
        PH_READY = 3'b001,
        PH_BUZZ  = 3'b010,
        PH_LIGHT = 3'b100
    } t_phase;

    // Elapsed ticks from a stamp to now, wrapping with the counter.
    function automatic t_time fhli_since(input t_time now, input t_time stamp);
        return now - stamp;
    endfunction

    // Elapsed time strictly greater than a register value.
    function automatic logic fhli_gt(input t_time diff, input logic [15:0] lim);
        return CMP_W'(diff) > CMP_W'(lim);
    endfunction

    // Elapsed time strictly less than a register value.
    function automatic logic fhli_lt(input t_time diff, input logic [15:0] lim);
        return CMP_W'(diff) < CMP_W'(lim);
    endfunction

endpackage

@@ rtl/foil_hit_lockout_indicator_top.sv @@
// ----------------------------------------------------------------------------
// Foil hit lockout indicator top level
// Tip samples in, lamp and buzzer drives out, with a register config port.
// ----------------------------------------------------------------------------
// Each input beat carries both tip levels for one millisecond tick and gives
// exactly one output beat with the lamp, buzzer and buzzer-armed levels after
// that tick. Beats are registered on input, the tick update is combinational
// between the input register and the result register, and a new beat is
// taken every clock unless a waiting result blocks the output: throughput is
// one beat per cycle while the output is not stalled. A beat passes the input
// register and then the result register. The config port is always ready;
// registers should be written only while no beat is in flight.
module foil_hit_lockout_indicator_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_red_tip,
    input  logic                            i_green_tip,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_red_lamp,
    output logic                            o_green_lamp,
    output logic                            o_buzzer_on,
    output logic                            o_buzzer_enabled,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fhli_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fhli_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fhli_pkg::*;

    logic    r_in_valid;
    logic    r_red;
    logic    r_green;
    logic    r_out_valid;
    t_result r_res;
    t_result w_next;
    t_cfg    w_cfg;
    logic    w_step;

    // A held beat moves on when the result slot is free or being emptied.
    assign w_step      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_step;
    assign o_cfg_ready = 1'b1;

    fhli_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    fhli_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_red   (r_red),
        .i_green (r_green),
        .i_cfg   (w_cfg),
        .o_next  (w_next)
    );

    // Input register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_red   <= i_red_tip;
            r_green <= i_green_tip;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_res       <= '0;
        end else begin
            if (w_step) begin
                r_out_valid <= 1'b1;
                r_res       <= w_next;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_red_lamp       = r_res.red_lamp;
    assign o_green_lamp     = r_res.green_lamp;
    assign o_buzzer_on      = r_res.buzzer_on;
    assign o_buzzer_enabled = r_res.buzzer_enabled;

    // The buzzer only sounds together with at least one lamp.
    a_buzz_needs_lamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_buzzer_on |-> (o_red_lamp || o_green_lamp))
        else $error("buzzer on with both lamps dark");

    // A stepped beat always lands in the result register.
    a_step_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> o_out_valid)
        else $error("stepped beat did not produce a result");

    // Input stalls only when a held beat is blocked by a waiting result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && o_out_valid && !i_out_ready))
        else $error("input stalled without a blocked result");

endmodule

@@ rtl/fhli_cfg.sv @@
// ----------------------------------------------------------------------------
// Foil hit lockout indicator configuration registers
// Holds the six timing and threshold registers written over the config port.
// ----------------------------------------------------------------------------
module fhli_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr,
    input  logic [fhli_pkg::CFG_IDX_W-1:0] i_index,
    input  logic [fhli_pkg::CFG_DATA_W-1:0] i_data,
    output fhli_pkg::t_cfg                 o_cfg
);
    import fhli_pkg::*;

    t_cfg r_cfg;

    // Register writes; values are cut to their register widths.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_press_ticks   <= RST_MIN_HIT;
            r_cfg.lockout_ticks     <= RST_LOCKOUT;
            r_cfg.buzz_ticks        <= RST_BUZZER;
            r_cfg.light_time        <= RST_LIGHT;
            r_cfg.disconnect_window <= RST_DISC_WIN;
            r_cfg.disconnect_count  <= RST_DISC_COUNT;
        end else if (i_wr) begin
            unique case (i_index)
                CFG_MIN_HIT:    r_cfg.min_press_ticks   <= i_data[9:0];
                CFG_LOCKOUT:    r_cfg.lockout_ticks     <= i_data[13:0];
                CFG_BUZZER:     r_cfg.buzz_ticks        <= i_data[15:0];
                CFG_LIGHT:      r_cfg.light_time        <= i_data[15:0];
                CFG_DISC_WIN:   r_cfg.disconnect_window <= i_data[13:0];
                CFG_DISC_COUNT: r_cfg.disconnect_count  <= i_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/fhli_core.sv @@
// ----------------------------------------------------------------------------
// Foil hit lockout indicator core
// Scoring state and the single-tick update applied once per stepped item.
// ----------------------------------------------------------------------------
module fhli_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_red,
    input  logic              i_green,
    input  fhli_pkg::t_cfg    i_cfg,
    output fhli_pkg::t_result o_next
);
    import fhli_pkg::*;

    t_phase      r_phase, n_phase;
    t_time       r_tick, n_tick;
    t_time       r_red_start, n_red_start;
    t_time       r_green_start, n_green_start;
    t_time       r_win_start, n_win_start;
    t_time       r_last_clear, n_last_clear;
    logic        r_red_held, n_red_held;
    logic        r_green_held, n_green_held;
    logic        r_win_open, n_win_open;
    logic        r_armed, n_armed;
    logic [7:0]  r_repeat, n_repeat;
    logic [15:0] r_timer, n_timer;
    logic        r_lamp_red, n_lamp_red;
    logic        r_lamp_green, n_lamp_green;
    logic        r_buzz, n_buzz;
    logic [7:0]  w_limit;
    logic        w_go_light;
    logic        w_go_clear;

    // Repeat-hit threshold; small counts collapse to zero.
    assign w_limit = (i_cfg.disconnect_count < 8'd2) ? 8'd0
                                                     : i_cfg.disconnect_count - 8'd2;

    // Next state for one tick, following the ready / buzzer / light sequence.
    always_comb begin
        n_phase       = r_phase;
        n_tick        = r_tick + t_time'(1);
        n_red_start   = r_red_start;
        n_green_start = r_green_start;
        n_win_start   = r_win_start;
        n_last_clear  = r_last_clear;
        n_red_held    = r_red_held;
        n_green_held  = r_green_held;
        n_win_open    = r_win_open;
        n_armed       = r_armed;
        n_repeat      = r_repeat;
        n_timer       = r_timer;
        n_lamp_red    = r_lamp_red;
        n_lamp_green  = r_lamp_green;
        n_buzz        = r_buzz;
        w_go_light    = 1'b0;
        w_go_clear    = 1'b0;

        unique case (r_phase)
            PH_READY: begin
                // A quiet period after the last clear rearms the buzzer.
                if (!r_armed &&
                    fhli_gt(fhli_since(r_tick, r_last_clear),
                            16'(i_cfg.disconnect_window))) begin
                    n_armed  = 1'b1;
                    n_repeat = 8'd0;
                end
                // Red tip tracking.
                if (!i_red) begin
                    n_red_held = 1'b0;
                end else if (!r_red_held) begin
                    n_red_start = r_tick;
                    n_red_held  = 1'b1;
                end else if (fhli_gt(fhli_since(r_tick, r_red_start),
                                     16'(i_cfg.min_press_ticks))) begin
                    if (!n_win_open) begin
                        n_win_start = r_red_start;
                        n_win_open  = 1'b1;
                    end
                    n_lamp_red = 1'b1;
                    if (n_armed) begin
                        n_buzz = 1'b1;
                    end
                end
                // Green tip tracking; red has priority in dating the window.
                if (!i_green) begin
                    n_green_held = 1'b0;
                end else if (!r_green_held) begin
                    n_green_start = r_tick;
                    n_green_held  = 1'b1;
                end else if (fhli_gt(fhli_since(r_tick, r_green_start),
                                     16'(i_cfg.min_press_ticks))) begin
                    if (!n_win_open) begin
                        n_win_start = r_green_start;
                        n_win_open  = 1'b1;
                    end
                    n_lamp_green = 1'b1;
                    if (n_armed) begin
                        n_buzz = 1'b1;
                    end
                end
                // Lockout expiry: repeat-hit check, then the buzzer phase.
                if (n_win_open &&
                    fhli_gt(fhli_since(r_tick, n_win_start),
                            16'(i_cfg.lockout_ticks))) begin
                    if (fhli_lt(fhli_since(r_tick, r_last_clear),
                                16'(i_cfg.disconnect_window))) begin
                        if (n_repeat < REPEAT_MAX) begin
                            n_repeat = n_repeat + 8'd1;
                        end
                        if (n_repeat > w_limit) begin
                            n_armed = 1'b0;
                        end
                    end
                    n_phase = PH_BUZZ;
                    n_timer = i_cfg.buzz_ticks;
                    if (i_cfg.buzz_ticks == 16'd0) begin
                        w_go_light = 1'b1;
                    end
                end
            end
            PH_BUZZ: begin
                n_timer = r_timer - 16'd1;
                if (n_timer == 16'd0) begin
                    w_go_light = 1'b1;
                end
            end
            PH_LIGHT: begin
                n_timer = r_timer - 16'd1;
                if (n_timer == 16'd0) begin
                    w_go_clear = 1'b1;
                end
            end
            default: begin
                n_phase = PH_READY;
            end
        endcase

        // Buzzer stops and the light phase begins.
        if (w_go_light) begin
            n_buzz  = 1'b0;
            n_phase = PH_LIGHT;
            n_timer = i_cfg.light_time;
            if (i_cfg.light_time == 16'd0) begin
                w_go_clear = 1'b1;
            end
        end

        // End of the bout action: lamps, buzzer, tip and window tracking return to ready.
        if (w_go_clear) begin
            n_last_clear  = r_tick;
            n_lamp_red    = 1'b0;
            n_lamp_green  = 1'b0;
            n_buzz        = 1'b0;
            n_red_start   = '0;
            n_green_start = '0;
            n_win_start   = '0;
            n_red_held    = 1'b0;
            n_green_held  = 1'b0;
            n_win_open    = 1'b0;
            n_timer       = 16'd0;
            n_phase       = PH_READY;
        end
    end

    // State update, once per stepped item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_READY;
            r_tick        <= '0;
            r_red_start   <= '0;
            r_green_start <= '0;
            r_win_start   <= '0;
            r_last_clear  <= '0;
            r_red_held    <= 1'b0;
            r_green_held  <= 1'b0;
            r_win_open    <= 1'b0;
            r_armed       <= 1'b1;
            r_repeat      <= 8'd0;
            r_timer       <= 16'd0;
            r_lamp_red    <= 1'b0;
            r_lamp_green  <= 1'b0;
            r_buzz        <= 1'b0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_tick        <= n_tick;
            r_red_start   <= n_red_start;
            r_green_start <= n_green_start;
            r_win_start   <= n_win_start;
            r_last_clear  <= n_last_clear;
            r_red_held    <= n_red_held;
            r_green_held  <= n_green_held;
            r_win_open    <= n_win_open;
            r_armed       <= n_armed;
            r_repeat      <= n_repeat;
            r_timer       <= n_timer;
            r_lamp_red    <= n_lamp_red;
            r_lamp_green  <= n_lamp_green;
            r_buzz        <= n_buzz;
        end
    end

    assign o_next.red_lamp       = n_lamp_red;
    assign o_next.green_lamp     = n_lamp_green;
    assign o_next.buzzer_on      = n_buzz;
    assign o_next.buzzer_enabled = n_armed;

endmodule
